// ----- src/msos_pkg.sv -----
// Shared constants, types and helpers for the multi-stepper order sequencer.
package msos_pkg;

  // Default sizing
  localparam int MOTORS_DEF      = 4;
  localparam int ORDER_DEPTH_DEF = 8;

  // Field widths
  localparam int MOTOR_W    = 2;
  localparam int COUNT_W    = 16;
  localparam int STEP_W     = 17;
  localparam int PERIOD_W   = 8;
  localparam int COIL_W     = 4;
  localparam int OUT_MOTORS = 4;
  localparam int COILS_W    = COIL_W * OUT_MOTORS;

  // Configuration register file
  localparam int NUM_REGS  = 4;
  localparam int CFG_IDX_W = 4;

  localparam logic [PERIOD_W-1:0] LIMIT_RESET   = 8'd108;
  localparam logic [PERIOD_W-1:0] PERIOD_RELOAD = 8'hFF;
  localparam logic [STEP_W-1:0]   EXTRA_STEPS   = 17'd4;

  // Operation codes of an input word
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PUSH = 1'b1
  } op_t;

  // Coil phases
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;
  localparam logic [1:0] PH_D = 2'd3;

  // One queued move order
  typedef struct packed {
    logic               dir;
    logic [COUNT_W-1:0] count;
  } order_t;

  // Energize the coil of the current phase and release the opposite one
  function automatic logic [COIL_W-1:0] coil_drive(input logic [1:0] ph,
                                                   input logic [COIL_W-1:0] c);
    logic [COIL_W-1:0] r;
    r = c;
    case (ph)
      PH_A:    r = (c & ~4'b0100) | 4'b0001;
      PH_B:    r = (c & ~4'b1000) | 4'b0010;
      PH_C:    r = (c & ~4'b0001) | 4'b0100;
      default: r = (c & ~4'b0010) | 4'b1000;
    endcase
    return r;
  endfunction

endpackage

// ----- src/msos_in_if.sv -----
// Input word channel: tick or push of a move order.
interface msos_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [msos_pkg::MOTOR_W-1:0] motor;
  logic [msos_pkg::COUNT_W-1:0] move_count;
  logic                        direction;

  modport source (output valid, op, motor, move_count, direction, input ready);
  modport sink   (input valid, op, motor, move_count, direction, output ready);
endinterface

// ----- src/msos_out_if.sv -----
// Result word channel: coil state and per-motor status.
interface msos_out_if;
  logic                            valid;
  logic                            ready;
  logic [msos_pkg::COILS_W-1:0]    coils;
  logic [msos_pkg::OUT_MOTORS-1:0] orders_done;
  logic [msos_pkg::OUT_MOTORS-1:0] busy_res;
  logic                            push_dropped;

  modport source (output valid, coils, orders_done, busy_res, push_dropped, input ready);
  modport sink   (input valid, coils, orders_done, busy_res, push_dropped, output ready);
endinterface

// ----- src/msos_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface msos_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [msos_pkg::CFG_IDX_W-1:0] index;
  logic [msos_pkg::PERIOD_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/multi_stepper_order_sequencer.sv -----
// Multi-stepper order sequencer: per-motor order queues, step timing and coil drive.
//
//   channel  dir  payload                                          handshake
//   in_ch    in   op, motor, move_count, direction                 valid/ready
//   out_ch   out  coils, orders_done, busy_res, push_dropped       valid/ready
//   cfg_ch   in   index, data (period_limit_0..3)                  valid/ready
//
// One word per cycle while in_ch is not stalled; its result word is registered and shows up in the next cycle.
// All motors update in parallel in the same cycle from their own state registers.
// rst_n (synchronous) clears queues, timers and coils; periods load 255, limits 108.
// in_ch stalls only while a result word is held and out_ch is not ready.
// cfg_ch is always ready; a write lands at the next clock edge.
module multi_stepper_order_sequencer #(
  parameter int MOTORS      = msos_pkg::MOTORS_DEF,
  parameter int ORDER_DEPTH = msos_pkg::ORDER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  msos_in_if.sink           in_ch,
  msos_out_if.source        out_ch,
  msos_cfg_if.sink          cfg_ch
);

  localparam int AW = (ORDER_DEPTH > 1) ? $clog2(ORDER_DEPTH) : 1;
  localparam int FW = $clog2(ORDER_DEPTH + 1);
  localparam int SW = FW + 1;

  logic in_acc;
  logic cfg_acc;

  // Result register
  logic                              out_valid_r;
  logic [msos_pkg::COILS_W-1:0]      coils_r;
  logic [msos_pkg::OUT_MOTORS-1:0]   done_r;
  logic [msos_pkg::OUT_MOTORS-1:0]   busy_r;
  logic                              dropped_r;

  // Per-motor results of the current word
  logic [msos_pkg::COIL_W-1:0]       coil_new [MOTORS];
  logic [MOTORS-1:0]                 busy_new;
  logic [MOTORS-1:0]                 done_new;
  logic [MOTORS-1:0]                 drop_new;

  logic [msos_pkg::COILS_W-1:0]      coils_c;
  logic [msos_pkg::OUT_MOTORS-1:0]   done_c;
  logic [msos_pkg::OUT_MOTORS-1:0]   busy_c;

  logic [msos_pkg::PERIOD_W-1:0]     limit_r [msos_pkg::NUM_REGS];

  // Handshakes
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  // Period limit registers; writes past the list are dropped
  always_ff @(posedge clk) begin
    for (int r = 0; r < msos_pkg::NUM_REGS; r++) begin
      if (!rst_n) begin
        limit_r[r] <= msos_pkg::LIMIT_RESET;
      end else if (cfg_acc && cfg_ch.index == msos_pkg::CFG_IDX_W'(r)) begin
        limit_r[r] <= cfg_ch.data;
      end
    end
  end

  // Pack the first four motors into the result word
  for (genvar j = 0; j < msos_pkg::OUT_MOTORS; j++) begin : g_pack
    if (j < MOTORS) begin : g_on
      assign coils_c[j*msos_pkg::COIL_W +: msos_pkg::COIL_W] = coil_new[j];
      assign done_c[j] = done_new[j];
      assign busy_c[j] = busy_new[j];
    end else begin : g_off
      assign coils_c[j*msos_pkg::COIL_W +: msos_pkg::COIL_W] = '0;
      assign done_c[j] = 1'b0;
      assign busy_c[j] = 1'b0;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (in_acc) begin
      coils_r   <= coils_c;
      done_r    <= done_c;
      busy_r    <= busy_c;
      dropped_r <= |drop_new;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.coils        = coils_r;
  assign out_ch.orders_done  = done_r;
  assign out_ch.busy_res     = busy_r;
  assign out_ch.push_dropped = dropped_r;

  // One lane per motor: queue memory, step timer and coil drive
  for (genvar m = 0; m < MOTORS; m++) begin : g_mot
    logic [msos_pkg::COIL_W-1:0]   coil_r, coil_nxt;
    logic [1:0]                    phase_r, phase_nxt;
    logic [msos_pkg::STEP_W-1:0]   step_r, step_nxt;
    logic [msos_pkg::PERIOD_W-1:0] timer_r, timer_nxt;
    logic [msos_pkg::PERIOD_W-1:0] period_r, period_nxt;
    logic [msos_pkg::PERIOD_W-1:0] limit_m;
    logic [AW-1:0]                 head_r, head_nxt, head_inc;
    logic [AW-1:0]                 wr_addr, rd_addr0, rd_addr1;
    logic [SW-1:0]                 wr_sum;
    logic [FW-1:0]                 fill_r, fill_nxt;
    logic                          wr_en, done_m, drop_m;
    msos_pkg::order_t              wr_data, cur_r, nxt_r;
    msos_pkg::order_t              mem [ORDER_DEPTH];

    if (m < msos_pkg::NUM_REGS) begin : g_lim
      assign limit_m = limit_r[m];
    end else begin : g_fix
      assign limit_m = msos_pkg::LIMIT_RESET;
    end

    // Queue addressing (circular, no power-of-two assumption)
    assign head_inc = (head_r == AW'(ORDER_DEPTH - 1)) ? '0 : head_r + 1'b1;
    assign wr_sum   = SW'(head_r) + SW'(fill_r);
    assign wr_addr  = (wr_sum >= SW'(ORDER_DEPTH)) ? AW'(wr_sum - SW'(ORDER_DEPTH))
                                                    : AW'(wr_sum);
    assign rd_addr0 = head_nxt;
    assign rd_addr1 = (head_nxt == AW'(ORDER_DEPTH - 1)) ? '0 : head_nxt + 1'b1;
    assign wr_data  = '{dir: in_ch.direction, count: in_ch.move_count};

    // Push or tick for this motor
    always_comb begin
      logic [msos_pkg::PERIOD_W-1:0] per;
      logic [msos_pkg::STEP_W-1:0]   target;
      coil_nxt   = coil_r;
      phase_nxt  = phase_r;
      step_nxt   = step_r;
      timer_nxt  = timer_r;
      period_nxt = period_r;
      head_nxt   = head_r;
      fill_nxt   = fill_r;
      wr_en      = 1'b0;
      done_m     = 1'b0;
      drop_m     = 1'b0;
      per        = period_r;
      target     = {1'b0, cur_r.count} + msos_pkg::EXTRA_STEPS;
      if (in_acc) begin
        if (in_ch.op == msos_pkg::OP_PUSH) begin
          if (32'(in_ch.motor) == m) begin
            if (fill_r >= FW'(ORDER_DEPTH)) begin
              drop_m = 1'b1;
            end else begin
              if (fill_r == '0) begin
                phase_nxt = in_ch.direction ? msos_pkg::PH_D : msos_pkg::PH_A;
              end
              wr_en    = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end
          end
        end else if (timer_r == period_r) begin
          timer_nxt = '0;
          if (fill_r != '0) begin
            coil_nxt  = msos_pkg::coil_drive(phase_r, coil_r);
            phase_nxt = cur_r.dir ? phase_r - 2'd1 : phase_r + 2'd1;
            if (step_r == target) begin
              // last step of the order: release coils and pop
              coil_nxt = '0;
              per      = msos_pkg::PERIOD_RELOAD;
              if (fill_r > FW'(1)) begin
                phase_nxt = nxt_r.dir ? msos_pkg::PH_D : msos_pkg::PH_A;
              end
              step_nxt = '0;
              head_nxt = head_inc;
              fill_nxt = fill_r - 1'b1;
              done_m   = 1'b1;
            end else begin
              step_nxt = step_r + 1'b1;
            end
            // ramp toward the fastest allowed period
            if (per > limit_m) begin
              per = per - 1'b1;
            end
            period_nxt = per;
          end
        end else begin
          timer_nxt = timer_r + 1'b1;
        end
      end
    end

    // Order memory with registered head and head+1 reads, write bypass
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      cur_r <= (wr_en && wr_addr == rd_addr0) ? wr_data : mem[rd_addr0];
      nxt_r <= (wr_en && wr_addr == rd_addr1) ? wr_data : mem[rd_addr1];
    end

    // Motor state
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coil_r   <= '0;
        phase_r  <= msos_pkg::PH_A;
        step_r   <= '0;
        timer_r  <= '0;
        period_r <= msos_pkg::PERIOD_RELOAD;
        head_r   <= '0;
        fill_r   <= '0;
      end else begin
        coil_r   <= coil_nxt;
        phase_r  <= phase_nxt;
        step_r   <= step_nxt;
        timer_r  <= timer_nxt;
        period_r <= period_nxt;
        head_r   <= head_nxt;
        fill_r   <= fill_nxt;
      end
    end

    assign coil_new[m] = coil_nxt;
    assign busy_new[m] = (fill_nxt != '0);
    assign done_new[m] = done_m;
    assign drop_new[m] = drop_m;

    // Queue never holds more orders than it has room for
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
      fill_r <= FW'(ORDER_DEPTH))
      else $error("order queue overfilled");

    // An idle motor keeps its coils released
    a_idle_coils: assert property (@(posedge clk) disable iff (!rst_n)
      fill_r == '0 |-> coil_r == '0)
      else $error("coils driven with empty queue");

    // A tick short of the period only advances the timer
    a_timer_step: assert property (@(posedge clk) disable iff (!rst_n)
      in_acc && in_ch.op == msos_pkg::OP_TICK && timer_r != period_r
      |=> timer_r == $past(timer_r) + 8'd1 && step_r == $past(step_r))
      else $error("timer did not advance");
  end

endmodule

// ----- sim/multi_stepper_order_sequencer_tb.sv -----
// Self-checking bench for the multi-stepper order sequencer: directed words, then random phases.
module multi_stepper_order_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MOTORS       = msos_pkg::MOTORS_DEF;
  localparam int DEPTH        = msos_pkg::ORDER_DEPTH_DEF;
  localparam int PHASES       = 4;
  // Mostly ticks, so step timers of motors with queued orders advance in each phase
  localparam int PHASE_WORDS  = 170;
  localparam int REPICK_EVERY = 40;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PLAN_ROWS    = 17;

  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  typedef enum logic [msos_pkg::CFG_IDX_W-1:0] {
    REG_PERIOD_LIMIT_0 = 4'd0,
    REG_PERIOD_LIMIT_1 = 4'd1,
    REG_PERIOD_LIMIT_2 = 4'd2,
    REG_PERIOD_LIMIT_3 = 4'd3,
    REG_UNMAPPED       = 4'd15
  } reg_idx_t;

  typedef struct packed {
    msos_pkg::op_t                op;
    logic [msos_pkg::MOTOR_W-1:0] motor;
    logic [msos_pkg::COUNT_W-1:0] count;
    logic                         dir;
  } word_t;

  typedef struct packed {
    logic [msos_pkg::COILS_W-1:0]    coils;
    logic [msos_pkg::OUT_MOTORS-1:0] done;
    logic [msos_pkg::OUT_MOTORS-1:0] busy;
    logic                            dropped;
  } status_t;

  typedef struct {
    word_t   w;
    bit      typed;
    status_t res;
  } plan_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  msos_in_if  in_ch ();
  msos_out_if out_ch ();
  msos_cfg_if cfg_ch ();

  multi_stepper_order_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Predicted sequencer state
  logic [msos_pkg::PERIOD_W-1:0] period_floor [msos_pkg::NUM_REGS];
  logic [msos_pkg::COIL_W-1:0]   energized    [MOTORS];
  logic [1:0]                    coil_phase   [MOTORS];
  logic [msos_pkg::STEP_W-1:0]   steps_taken  [MOTORS];
  logic [msos_pkg::PERIOD_W-1:0] tick_cnt     [MOTORS];
  logic [msos_pkg::PERIOD_W-1:0] step_ticks   [MOTORS];
  msos_pkg::order_t              order_q      [MOTORS][DEPTH];
  int                            q_head       [MOTORS];
  int                            q_fill       [MOTORS];

  status_t     due_status [$];
  int          fail_count = 0;
  int unsigned cycle_cnt  = 0;
  bit          send_gaps  = 1'b1;
  bit          recv_stalls = 1'b1;

  const reg_idx_t limit_reg [msos_pkg::NUM_REGS] = '{REG_PERIOD_LIMIT_0, REG_PERIOD_LIMIT_1,
                                                     REG_PERIOD_LIMIT_2, REG_PERIOD_LIMIT_3};

  // Directed words: reset state, queue fill on motor 3, full-queue drops, both directions
  plan_row_t plan [PLAN_ROWS] = '{
    '{'{msos_pkg::OP_TICK, 2'd0, 16'h0000, DIR_CW},  1'b1, '{16'h0000, 4'h0, 4'h0, 1'b0}},
    '{'{msos_pkg::OP_PUSH, 2'd0, 16'h0000, DIR_CW},  1'b1, '{16'h0000, 4'h0, 4'h1, 1'b0}},
    '{'{msos_pkg::OP_PUSH, 2'd1, 16'h0001, DIR_CCW}, 1'b1, '{16'h0000, 4'h0, 4'h3, 1'b0}},
    '{'{msos_pkg::OP_PUSH, 2'd2, 16'h0002, DIR_CW},  1'b1, '{16'h0000, 4'h0, 4'h7, 1'b0}},
    '{'{msos_pkg::OP_PUSH, 2'd3, 16'h0000, DIR_CCW}, 1'b1, '{16'h0000, 4'h0, 4'hF, 1'b0}},
    '{'{msos_pkg::OP_PUSH, 2'd3, 16'h0003, DIR_CW},  1'b1, '{16'h0000, 4'h0, 4'hF, 1'b0}},
    '{'{msos_pkg::OP_PUSH, 2'd3, 16'h0000, DIR_CCW}, 1'b1, '{16'h0000, 4'h0, 4'hF, 1'b0}},
    '{'{msos_pkg::OP_PUSH, 2'd3, 16'h0002, DIR_CW},  1'b1, '{16'h0000, 4'h0, 4'hF, 1'b0}},
    '{'{msos_pkg::OP_PUSH, 2'd3, 16'h0001, DIR_CCW}, 1'b1, '{16'h0000, 4'h0, 4'hF, 1'b0}},
    '{'{msos_pkg::OP_PUSH, 2'd3, 16'h0000, DIR_CW},  1'b1, '{16'h0000, 4'h0, 4'hF, 1'b0}},
    '{'{msos_pkg::OP_PUSH, 2'd3, 16'h0001, DIR_CCW}, 1'b1, '{16'h0000, 4'h0, 4'hF, 1'b0}},
    '{'{msos_pkg::OP_PUSH, 2'd3, 16'h0003, DIR_CW},  1'b1, '{16'h0000, 4'h0, 4'hF, 1'b0}},
    '{'{msos_pkg::OP_PUSH, 2'd3, 16'hFFFF, DIR_CCW}, 1'b1, '{16'h0000, 4'h0, 4'hF, 1'b1}},
    '{'{msos_pkg::OP_PUSH, 2'd3, 16'hFFFF, DIR_CW},  1'b1, '{16'h0000, 4'h0, 4'hF, 1'b1}},
    '{'{msos_pkg::OP_PUSH, 2'd0, 16'h0000, DIR_CCW}, 1'b1, '{16'h0000, 4'h0, 4'hF, 1'b0}},
    '{'{msos_pkg::OP_TICK, 2'd3, 16'hFFFF, DIR_CCW}, 1'b0, '0},
    '{'{msos_pkg::OP_TICK, 2'd1, 16'h5A5A, DIR_CW},  1'b0, '0}
  };

  function automatic void reset_state();
    for (int m = 0; m < msos_pkg::NUM_REGS; m++) period_floor[m] = msos_pkg::LIMIT_RESET;
    for (int m = 0; m < MOTORS; m++) begin
      energized[m]   = '0;
      coil_phase[m]  = msos_pkg::PH_A;
      steps_taken[m] = '0;
      tick_cnt[m]    = '0;
      step_ticks[m]  = msos_pkg::PERIOD_RELOAD;
      q_head[m]      = 0;
      q_fill[m]      = 0;
      for (int s = 0; s < DEPTH; s++) order_q[m][s] = '0;
    end
  endfunction

  // One step of a busy motor; returns 1 when its head order completes
  function automatic bit take_step(input int m);
    msos_pkg::order_t cur;
    msos_pkg::order_t nxt;
    logic [1:0]       p;
    bit               done;
    cur  = order_q[m][q_head[m]];
    p    = coil_phase[m];
    done = 1'b0;
    // energize this phase's coil, release the opposite one
    energized[m][p]         = 1'b1;
    energized[m][p ^ 2'd2]  = 1'b0;
    coil_phase[m] = (cur.dir == DIR_CCW) ? p - 2'd1 : p + 2'd1;
    if (steps_taken[m] == {1'b0, cur.count} + msos_pkg::EXTRA_STEPS) begin
      energized[m]  = '0;
      step_ticks[m] = msos_pkg::PERIOD_RELOAD;
      if (q_fill[m] > 1) begin
        nxt = order_q[m][(q_head[m] + 1) % DEPTH];
        coil_phase[m] = (nxt.dir == DIR_CCW) ? msos_pkg::PH_D : msos_pkg::PH_A;
      end
      steps_taken[m] = '0;
      tick_cnt[m]    = '0;
      q_head[m]      = (q_head[m] + 1) % DEPTH;
      q_fill[m]      = q_fill[m] - 1;
      done           = 1'b1;
    end else begin
      steps_taken[m] = steps_taken[m] + 1'b1;
    end
    // ramp toward the configured fastest period
    if (step_ticks[m] > period_floor[m]) step_ticks[m] = step_ticks[m] - 1'b1;
    return done;
  endfunction

  // Status word the sequencer should return for one input word
  function automatic status_t apply_word(input word_t w);
    status_t r;
    int      m;
    r = '0;
    if (w.op == msos_pkg::OP_PUSH) begin
      m = w.motor;
      if (q_fill[m] >= DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        if (q_fill[m] == 0) coil_phase[m] = (w.dir == DIR_CCW) ? msos_pkg::PH_D : msos_pkg::PH_A;
        order_q[m][(q_head[m] + q_fill[m]) % DEPTH] = '{dir: w.dir, count: w.count};
        q_fill[m] = q_fill[m] + 1;
      end
    end else begin
      for (int k = 0; k < MOTORS; k++) begin
        if (tick_cnt[k] == step_ticks[k]) begin
          if (q_fill[k] != 0) begin
            if (take_step(k)) r.done[k] = 1'b1;
          end
          tick_cnt[k] = '0;
        end else begin
          tick_cnt[k] = tick_cnt[k] + 1'b1;
        end
      end
    end
    for (int k = 0; k < MOTORS; k++) begin
      r.coils[msos_pkg::COIL_W*k +: msos_pkg::COIL_W] = energized[k];
      r.busy[k] = (q_fill[k] != 0);
    end
    return r;
  endfunction

  // Mostly ticks; pushes carry short orders, or any count when aimed at a full queue
  function automatic word_t make_word();
    word_t w;
    int    m;
    w.op    = msos_pkg::OP_TICK;
    w.motor = msos_pkg::MOTOR_W'($urandom_range(0, MOTORS - 1));
    w.count = msos_pkg::COUNT_W'($urandom);
    w.dir   = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 39) == 0) begin
      w.op = msos_pkg::OP_PUSH;
      m    = w.motor;
      if (q_fill[m] < DEPTH) w.count = msos_pkg::COUNT_W'($urandom_range(0, 2));
    end
    return w;
  endfunction

  // Drive one input word, wait for the handshake, then record what is due
  task automatic send_word(input word_t w, input bit typed, input status_t fixed);
    int gap;
    if (send_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.op         = w.op;
    in_ch.motor      = w.motor;
    in_ch.move_count = w.count;
    in_ch.direction  = w.dir;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (typed) begin
      void'(apply_word(w));
      due_status.push_back(fixed);
    end else begin
      due_status.push_back(apply_word(w));
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [msos_pkg::PERIOD_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx < msos_pkg::NUM_REGS) period_floor[idx] = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Stop sending and let every due word come back before touching registers
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (due_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [msos_pkg::COILS_W-1:0] want,
                             input logic [msos_pkg::COILS_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Result channel: random back-pressure in bursts
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!recv_stalls) begin
        out_ch.ready = 1'b1;
        stall_left   = 0;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        out_ch.ready = 1'b0;
        stall_left   = $urandom_range(0, 14);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Compare each returned word against the oldest one due
  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.coils, out_ch.orders_done, out_ch.busy_res, out_ch.push_dropped};
      if (due_status.size() == 0) begin
        fail_count++;
        $display("%0t ns: word %h returned with none due", $time, got);
      end else begin
        want = due_status.pop_front();
        check_field("coils", want.coils, got.coils);
        check_field("orders_done", msos_pkg::COILS_W'(want.done),
                    msos_pkg::COILS_W'(got.done));
        check_field("busy_res", msos_pkg::COILS_W'(want.busy),
                    msos_pkg::COILS_W'(got.busy));
        check_field("push_dropped", msos_pkg::COILS_W'(want.dropped),
                    msos_pkg::COILS_W'(got.dropped));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [msos_pkg::PERIOD_W-1:0] floors [msos_pkg::NUM_REGS];
    in_ch.valid      = 1'b0;
    in_ch.op         = msos_pkg::OP_TICK;
    in_ch.motor      = '0;
    in_ch.move_count = '0;
    in_ch.direction  = DIR_CW;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_PERIOD_LIMIT_0;
    cfg_ch.data      = '0;
    reset_state();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed part at reset limits
    for (int r = 0; r < PLAN_ROWS; r++) send_word(plan[r].w, plan[r].typed, plan[r].res);

    // random phases, each at its own set of period limits
    for (int p = 0; p < PHASES; p++) begin
      settle();
      for (int m = 0; m < msos_pkg::NUM_REGS; m++) begin
        case (p)
          0:       floors[m] = '0;
          1:       floors[m] = '1;
          2:       floors[m] = (m == 0) ? 8'd0 : (m == 1) ? 8'd255 : (m == 2) ? 8'd1 : 8'd254;
          default: floors[m] = msos_pkg::PERIOD_W'($urandom_range(0, 255));
        endcase
        write_reg(limit_reg[m], floors[m]);
      end
      write_reg(REG_UNMAPPED, msos_pkg::PERIOD_W'($urandom));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // switch idling on and off in stretches; none in the last phase
        if (i % REPICK_EVERY == 0) begin
          send_gaps   = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
          recv_stalls = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
        end
        send_word(make_word(), 1'b0, '0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/msos_pkg.sv
src/msos_in_if.sv
src/msos_out_if.sv
src/msos_cfg_if.sv
src/multi_stepper_order_sequencer.sv
sim/multi_stepper_order_sequencer_tb.sv
